// ----- src/fpis_pkg.sv -----
// Shared types, register indexes, reset values and helpers for the force PI loop.
// No dependencies; imported by every module of the block.
package fpis_pkg;

  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;
  localparam int InDataW  = 48;
  localparam int OutDataW = 72;

  typedef enum logic [CfgAddrW-1:0] {
    REG_FORCE_TARGET = 3'd0,
    REG_PROP_GAIN    = 3'd1,
    REG_INT_GAIN     = 3'd2,
    REG_SEP_THRESH   = 3'd3,
    REG_CORR_UPPER   = 3'd4,
    REG_CORR_LOWER   = 3'd5,
    REG_POS_LIMIT    = 3'd6
  } cfg_reg_idx_t;

  localparam logic [15:0]        RstForceTarget = 16'd0;
  localparam logic [7:0]         RstPropGain    = 8'd6;
  localparam logic [15:0]        RstIntGain     = 16'd6554;
  localparam logic [15:0]        RstSepThresh   = 16'd200;
  localparam logic signed [31:0] RstCorrUpper   = 32'sd500;
  localparam logic signed [31:0] RstCorrLower   = -32'sd500;
  localparam logic signed [31:0] RstPosLimit    = 32'sd2000;

  // hold window for steady large corrections
  localparam logic signed [31:0] HoldMinCorr  = 32'sd1000;
  localparam logic signed [63:0] HoldMaxDelta = 64'sd200;

  typedef struct packed {
    logic [15:0]        force_target;
    logic [7:0]         prop_gain;
    logic [15:0]        int_gain;
    logic [15:0]        sep_thresh;
    logic signed [31:0] corr_upper;
    logic signed [31:0] corr_lower;
    logic signed [31:0] pos_limit;
  } cfg_regs_t;

  typedef struct packed {
    logic signed [31:0] motor_position;
    logic [15:0]        measured_force;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] correction;
    logic               accel_changed;
    logic               accel_high;
    logic               issue_move;
    logic signed [31:0] target_position;
  } result_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- src/fpis_cfg.sv -----
// Configuration register file for the force PI loop.
// Depends on fpis_pkg; flags a force target write so the loop state can be cleared.
module fpis_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fpis_pkg::CfgAddrW-1:0] cfg_addr,
  input  logic [fpis_pkg::CfgDataW-1:0] cfg_data,
  output fpis_pkg::cfg_regs_t           regs,
  output logic                          loop_clear
);
  import fpis_pkg::*;

  cfg_regs_t regs_r, regs_nxt;
  logic      wr_en;

  assign cfg_ready  = 1'b1;
  assign wr_en      = cfg_valid && cfg_ready;
  assign loop_clear = wr_en && (cfg_addr == REG_FORCE_TARGET);
  assign regs       = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      case (cfg_addr)
        REG_FORCE_TARGET: regs_nxt.force_target = cfg_data[15:0];
        REG_PROP_GAIN:    regs_nxt.prop_gain    = cfg_data[7:0];
        REG_INT_GAIN:     regs_nxt.int_gain     = cfg_data[15:0];
        REG_SEP_THRESH:   regs_nxt.sep_thresh   = cfg_data[15:0];
        REG_CORR_UPPER:   regs_nxt.corr_upper   = $signed(cfg_data);
        REG_CORR_LOWER:   regs_nxt.corr_lower   = $signed(cfg_data);
        REG_POS_LIMIT:    regs_nxt.pos_limit    = $signed(cfg_data);
        default:          regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.force_target <= RstForceTarget;
      regs_r.prop_gain    <= RstPropGain;
      regs_r.int_gain     <= RstIntGain;
      regs_r.sep_thresh   <= RstSepThresh;
      regs_r.corr_upper   <= RstCorrUpper;
      regs_r.corr_lower   <= RstCorrLower;
      regs_r.pos_limit    <= RstPosLimit;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

// ----- src/fpis_core.sv -----
// PI step with integral separation, conditional anti-windup and move hold.
// Depends on fpis_pkg; holds the loop state and updates it when step_en is high.
module fpis_core #(
  parameter int HOLD_COUNT_LIMIT = 10,
  parameter int GAIN_FRAC_BITS   = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fpis_pkg::cfg_regs_t regs,
  input  logic                loop_clear,
  input  logic                step_en,
  input  fpis_pkg::in_item_t  item,
  output fpis_pkg::result_t   res
);
  import fpis_pkg::*;

  localparam logic signed [48:0] TruncBias = (49'sd1 <<< GAIN_FRAC_BITS) - 49'sd1;

  logic signed [31:0] isum_r, isum_nxt;
  logic signed [31:0] last_r, last_nxt;
  logic [3:0]         hcnt_r, hcnt_nxt;
  logic               accel_r, accel_nxt;

  logic               safety;
  logic signed [16:0] err, mag;
  logic               use_int, allow;
  logic signed [31:0] isum_upd;
  logic signed [48:0] prod, iterm;
  logic signed [25:0] pterm;
  logic signed [31:0] corr, tgt;
  logic signed [63:0] diff, adiff;
  logic               hold;

  always_comb begin
    safety  = item.motor_position > regs.pos_limit;
    err     = $signed({1'b0, regs.force_target}) - $signed({1'b0, item.measured_force});
    mag     = err[16] ? -err : err;
    use_int = mag <= $signed({1'b0, regs.sep_thresh});

    if (last_r > regs.corr_upper) begin
      allow = err[16];
    end else if (last_r < regs.corr_lower) begin
      allow = !err[16] && (err != 17'sd0);
    end else begin
      allow = 1'b1;
    end

    isum_upd = (use_int && allow) ? sat32(64'(isum_r) + 64'(err)) : isum_r;

    // integral term, truncated toward zero; operands are 32 x 17 bits
    prod  = 49'(isum_upd) * 49'($signed({1'b0, regs.int_gain}));
    iterm = use_int ? ((prod + (prod[48] ? TruncBias : 49'sd0)) >>> GAIN_FRAC_BITS)
                    : 49'sd0;
    pterm = 26'(err) * 26'($signed({1'b0, regs.prop_gain}));
    corr  = sat32(64'(pterm) + 64'(iterm));
    tgt   = sat32(64'(item.motor_position) - 64'(corr));

    diff  = 64'(corr) - 64'(last_r);
    adiff = diff[63] ? -diff : diff;
    hold  = (last_r > HoldMinCorr) && (corr > HoldMinCorr) && (adiff < HoldMaxDelta) &&
            (hcnt_r < 4'(HOLD_COUNT_LIMIT));

    isum_nxt  = isum_r;
    last_nxt  = last_r;
    hcnt_nxt  = hcnt_r;
    accel_nxt = accel_r;
    if (safety) begin
      accel_nxt           = 1'b1;
      res.target_position = 32'sd0;
      res.issue_move      = 1'b1;
      res.accel_high      = 1'b1;
      res.accel_changed   = !accel_r;
      res.correction      = 32'sd0;
    end else begin
      accel_nxt           = 1'b0;
      isum_nxt            = isum_upd;
      last_nxt            = corr;
      hcnt_nxt            = hold ? hcnt_r + 4'd1 : 4'd0;
      res.target_position = tgt;
      res.issue_move      = !hold;
      res.accel_high      = 1'b0;
      res.accel_changed   = accel_r;
      res.correction      = corr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || loop_clear) begin
      isum_r  <= 32'sd0;
      last_r  <= 32'sd0;
      hcnt_r  <= 4'd0;
      accel_r <= 1'b0;
    end else if (step_en) begin
      isum_r  <= isum_nxt;
      last_r  <= last_nxt;
      hcnt_r  <= hcnt_nxt;
      accel_r <= accel_nxt;
    end
  end

endmodule

// ----- src/force_pi_loop_integral_separation.sv -----
// Top level of the force PI loop: input register, PI step, result register.
// Depends on fpis_pkg, fpis_cfg and fpis_core.
//
//  channel  ports               request carries
//  -------  ------------------  ----------------------------------------------
//  in       in_tvalid/tready    measured_force, motor_position
//  out      out_tvalid/tready   target_position, issue_move, accel_high,
//                               accel_changed, correction
//  cfg      cfg_valid/ready     register index, write data (always ready)
//
// One request per cycle sustained while out_tready holds; a request taken goes to the
// input register, and its result is presented from the result register once the
// PI step has written it there.
// The PI step, with a 32x17 and a 17x9 multiply, sits between those registers.
// rst_n (synchronous) restores register defaults and clears the loop state.
// A stalled output holds its result; the input keeps accepting until both
// registers are full.
module force_pi_loop_integral_separation #(
  parameter int HOLD_COUNT_LIMIT = 10,
  parameter int GAIN_FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [fpis_pkg::InDataW-1:0]  in_tdata,   // measured_force, motor_position
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // target_position, issue_move, accel_high, accel_changed, correction, zero pad
  output logic [fpis_pkg::OutDataW-1:0] out_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fpis_pkg::CfgAddrW-1:0] cfg_addr,
  input  logic [fpis_pkg::CfgDataW-1:0] cfg_data
);
  import fpis_pkg::*;

  cfg_regs_t regs;
  logic      loop_clear;
  in_item_t  item_r;
  logic      item_vld_r;
  result_t   res, res_r;
  logic      res_vld_r;
  logic      advance;

  fpis_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .regs       (regs),
    .loop_clear (loop_clear)
  );

  fpis_core #(
    .HOLD_COUNT_LIMIT (HOLD_COUNT_LIMIT),
    .GAIN_FRAC_BITS   (GAIN_FRAC_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .regs       (regs),
    .loop_clear (loop_clear),
    .step_en    (advance),
    .item       (item_r),
    .res        (res)
  );

  assign advance    = item_vld_r && (!res_vld_r || out_tready);
  assign in_tready  = !item_vld_r || advance;
  assign out_tvalid = res_vld_r;
  assign out_tdata  = {5'd0, res_r.correction, res_r.accel_changed, res_r.accel_high,
                       res_r.issue_move, res_r.target_position};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      if (in_tready) begin
        item_vld_r <= in_tvalid;
      end
      if (advance) begin
        res_vld_r <= 1'b1;
      end else if (out_tready) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.measured_force <= in_tdata[15:0];
      item_r.motor_position <= $signed(in_tdata[47:16]);
    end
    if (advance) begin
      res_r <= res;
    end
  end

  a_step_lands : assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> res_vld_r)
    else $error("stepped item did not reach the result register");

  a_safety_form : assert property (@(posedge clk) disable iff (!rst_n)
    res_vld_r && res_r.accel_high |->
      res_r.target_position == 32'sd0 && res_r.issue_move && res_r.correction == 32'sd0)
    else $error("safety return result malformed");

  a_held_normal : assert property (@(posedge clk) disable iff (!rst_n)
    res_vld_r && !res_r.issue_move |-> !res_r.accel_high)
    else $error("move held on safety path");

  a_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> item_vld_r && res_vld_r)
    else $error("input stalled with free register");

endmodule
